FILE: hw/rtl/atc_pkg.sv
// shared types, constants and a helper function for the affine transform composer
package atc_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = 5;
    localparam int WORD_W       = 32;
    localparam int ACC_W        = 50;

    localparam logic [1:0] ACT_TRANSLATE = 2'd0;
    localparam logic [1:0] ACT_ROTATE    = 2'd1;
    localparam logic [1:0] ACT_SCALE     = 2'd2;
    localparam logic [1:0] ACT_NONE      = 2'd3;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [WORD_W-1:0] FX_ONE = WORD_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh80000000;

    // multiply operand selections
    localparam logic [3:0] MS_TX_A = 4'd0;
    localparam logic [3:0] MS_TX_B = 4'd1;
    localparam logic [3:0] MS_TY_A = 4'd2;
    localparam logic [3:0] MS_TY_B = 4'd3;
    localparam logic [3:0] MS_SX   = 4'd4;
    localparam logic [3:0] MS_SY   = 4'd5;
    localparam logic [3:0] MS_N0A  = 4'd6;
    localparam logic [3:0] MS_N0B  = 4'd7;

    typedef struct packed {
        logic       load;
        logic       cordic_step;
        logic       build_t;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic [2:0] n_idx;
        logic       acc_clear;
        logic       acc_add;
        logic       t_sat;
        logic       n_write;
        logic       commit;
    } atc_cmd_t;

    typedef struct packed {
        logic [1:0] action;
    } atc_status_t;

    function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                5'd0: r = 34'sd536870912;   5'd1: r = 34'sd316933406;
                5'd2: r = 34'sd167458907;   5'd3: r = 34'sd85004756;
                5'd4: r = 34'sd42667331;    5'd5: r = 34'sd21354465;
                5'd6: r = 34'sd10679838;    5'd7: r = 34'sd5340245;
                5'd8: r = 34'sd2670163;     5'd9: r = 34'sd1335086;
                5'd10: r = 34'sd667544;     5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;     5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41721;      5'd15: r = 34'sd20860;
                5'd16: r = 34'sd10430;      5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2607;       5'd19: r = 34'sd1303;
                5'd20: r = 34'sd651;        5'd21: r = 34'sd325;
                5'd22: r = 34'sd162;        5'd23: r = 34'sd81;
                5'd24: r = 34'sd40;         5'd25: r = 34'sd20;
                5'd26: r = 34'sd10;         5'd27: r = 34'sd5;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/atc_ctrl.sv
// controller state machine sequencing the cordic, transform build and matrix multiply
module atc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  atc_pkg::atc_status_t status,
    output atc_pkg::atc_cmd_t    cmd
);
    import atc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CORDIC = 3'd1;
    localparam logic [2:0] S_BUILD  = 3'd2;
    localparam logic [2:0] S_TMUL   = 3'd3;
    localparam logic [2:0] S_NMUL   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [2:0]        idx_reg, idx_next;
    logic              oval_reg, oval_next;

    assign in_ready  = (state_reg == S_IDLE) && !oval_reg;
    assign out_valid = oval_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        oval_next  = oval_reg;
        cmd        = '0;
        cmd.n_idx  = idx_reg;
        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                // only rotate needs the cordic; other actions pass quickly
                if (status.action == ACT_ROTATE)
                begin
                    cmd.cordic_step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                    begin
                        state_next = S_BUILD;
                    end
                end
                else if (status.action == ACT_NONE)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_BUILD;
                end
            end
            S_BUILD:
            begin
                cmd.build_t = 1'b1;
                cnt_next    = '0;
                state_next  = S_TMUL;
            end
            S_TMUL:
            begin
                // up to four products issued, then drain until the last product lands
                cnt_next = cnt_reg + 1'b1;
                if ((status.action == ACT_ROTATE) && (cnt_reg < 5'd4))
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = 4'(cnt_reg);
                end
                else if ((status.action == ACT_SCALE) && (cnt_reg < 5'd2))
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = (cnt_reg == 5'd0) ? MS_SX : MS_SY;
                end
                if (cnt_reg == 5'd6)
                begin
                    cmd.t_sat  = 1'b1;
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = S_NMUL;
                end
            end
            S_NMUL:
            begin
                // per entry: two products, then accumulate
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd0)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MS_N0A;
                end
                else if (cnt_reg == 5'd1)
                begin
                    cmd.mul_en    = 1'b1;
                    cmd.mul_sel   = MS_N0B;
                    cmd.acc_clear = 1'b1;
                end
                else if (cnt_reg == 5'd3)
                begin
                    cmd.acc_add = 1'b1;
                end
                else if (cnt_reg == 5'd4)
                begin
                    cmd.acc_add = 1'b1;
                    cmd.n_write = 1'b1;
                    cnt_next    = '0;
                    idx_next    = idx_reg + 1'b1;
                    if (idx_reg == 3'd5)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!oval_reg)
                begin
                    cmd.commit = 1'b1;
                    oval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            oval_reg  <= oval_next;
        end
    end

endmodule

FILE: hw/rtl/atc_datapath.sv
// datapath: request registers, cordic, shared multiplier, matrix state and result
module atc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  atc_pkg::atc_cmd_t           cmd,
    output atc_pkg::atc_status_t        status,
    input  logic [1:0]                  action,
    input  logic signed [31:0]          param_x,
    input  logic signed [31:0]          param_y,
    input  logic [15:0]                 angle,
    input  logic signed [31:0]          center_x,
    input  logic signed [31:0]          center_y,
    output logic signed [31:0]          m00,
    output logic signed [31:0]          m01,
    output logic signed [31:0]          m02,
    output logic signed [31:0]          m10,
    output logic signed [31:0]          m11,
    output logic signed [31:0]          m12,
    output logic                        overflow
);
    import atc_pkg::*;

    logic [1:0]               act_reg;
    logic signed [31:0]       px_reg, py_reg, cx_reg, cy_reg;
    logic [1:0]               quad_reg;
    logic signed [33:0]       x_reg, y_reg, z_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [ACC_W-1:0]  t_reg [6];
    logic signed [31:0]       ts_reg [6];
    logic signed [31:0]       mat_reg [6];
    logic signed [31:0]       n_reg [6];
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     ovf_reg;
    logic signed [33:0]       ma_reg, mb_reg;
    logic signed [67:0]       prod_reg;
    logic                     pv_reg, pv2_reg;
    logic [3:0]               psel_reg, psel2_reg;
    logic signed [ACC_W-1:0]  rnd_reg;

    logic [31:0]              ang_w;
    logic signed [33:0]       xs, ys;
    logic signed [ACC_W-1:0]  cq, sq, c_fx, s_fx;
    logic signed [33:0]       op_a, op_b;
    logic signed [67:0]       prod_rnd;
    logic [2:0]               r_base;
    logic [1:0]               kcol;
    logic signed [ACC_W-1:0]  acc_sum;

    assign status.action = act_reg;
    assign ang_w = {angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;

    assign cq = ACC_W'((x_reg + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    assign sq = ACC_W'((y_reg + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

    always_comb
    begin
        case (quad_reg)
            2'd0:    begin c_fx = cq;  s_fx = sq;  end
            2'd1:    begin c_fx = -sq; s_fx = cq;  end
            2'd2:    begin c_fx = -cq; s_fx = -sq; end
            default: begin c_fx = sq;  s_fx = -cq; end
        endcase
    end

    // entry n: row r = idx/3, column k = idx%3
    assign r_base = (cmd.n_idx >= 3'd3) ? 3'd3 : 3'd0;
    assign kcol   = 2'(cmd.n_idx - r_base);

    function automatic logic signed [33:0] ext(input logic signed [ACC_W-1:0] v);
        return 34'(v);
    endfunction

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            MS_TX_A: begin op_a = 34'(cx_reg); op_b = 34'(FX_ONE) - ext(t_reg[0]); end
            MS_TX_B: begin op_a = 34'(cy_reg); op_b = ext(t_reg[3]); end
            MS_TY_A: begin op_a = 34'(cy_reg); op_b = 34'(FX_ONE) - ext(t_reg[0]); end
            MS_TY_B: begin op_a = 34'(cx_reg); op_b = ext(t_reg[3]); end
            MS_SX:   begin op_a = 34'(FX_ONE) - 34'(px_reg); op_b = 34'(cx_reg); end
            MS_SY:   begin op_a = 34'(FX_ONE) - 34'(py_reg); op_b = 34'(cy_reg); end
            MS_N0A:  begin op_a = 34'(ts_reg[r_base]); op_b = 34'(mat_reg[3'(kcol)]); end
            MS_N0B:  begin op_a = 34'(ts_reg[r_base + 3'd1]);
                           op_b = 34'(mat_reg[3'(kcol) + 3'd3]); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod_rnd = (prod_reg + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    function automatic logic signed [31:0] sat(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(SAT_MAX))
            return SAT_MAX;
        if (v < ACC_W'(SAT_MIN))
            return SAT_MIN;
        return 32'(v);
    endfunction

    function automatic logic clips(input logic signed [ACC_W-1:0] v);
        return (v > ACC_W'(SAT_MAX)) || (v < ACC_W'(SAT_MIN));
    endfunction

    assign acc_sum = acc_reg + rnd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= FX_ONE; mat_reg[1] <= '0; mat_reg[2] <= '0;
            mat_reg[3] <= '0; mat_reg[4] <= FX_ONE; mat_reg[5] <= '0;
            overflow   <= 1'b0;
            act_reg    <= ACT_NONE;
            pv_reg     <= 1'b0;
            pv2_reg    <= 1'b0;
        end
        else
        begin
            pv_reg  <= cmd.mul_en;
            pv2_reg <= pv_reg;
            if (cmd.load)
            begin
                act_reg <= action;
            end
            if (cmd.commit)
            begin
                if (act_reg != ACT_NONE)
                begin
                    for (int k = 0; k < 6; k++)
                        mat_reg[k] <= n_reg[k];
                end
                overflow <= (act_reg != ACT_NONE) && ovf_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg   <= param_x;
            py_reg   <= param_y;
            cx_reg   <= center_x;
            cy_reg   <= center_y;
            quad_reg <= ang_w[31:30];
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= 34'({2'b00, ang_w[29:0]});
            step_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        if (cmd.cordic_step)
        begin
            step_reg <= step_reg + 1'b1;
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_q30(step_reg);
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_q30(step_reg);
            end
        end
        if (cmd.build_t)
        begin
            case (act_reg)
                ACT_TRANSLATE:
                begin
                    t_reg[0] <= ACC_W'(FX_ONE); t_reg[1] <= '0; t_reg[2] <= ACC_W'(px_reg);
                    t_reg[3] <= '0; t_reg[4] <= ACC_W'(FX_ONE); t_reg[5] <= ACC_W'(py_reg);
                end
                ACT_ROTATE:
                begin
                    t_reg[0] <= c_fx; t_reg[1] <= -s_fx; t_reg[2] <= '0;
                    t_reg[3] <= s_fx; t_reg[4] <= c_fx;  t_reg[5] <= '0;
                end
                default:
                begin
                    t_reg[0] <= ACC_W'(px_reg); t_reg[1] <= '0; t_reg[2] <= '0;
                    t_reg[3] <= '0; t_reg[4] <= ACC_W'(py_reg); t_reg[5] <= '0;
                end
            endcase
        end
        if (cmd.mul_en)
        begin
            ma_reg   <= op_a;
            mb_reg   <= op_b;
            psel_reg <= cmd.mul_sel;
        end
        if (pv_reg)
        begin
            prod_reg  <= ma_reg * mb_reg;
            psel2_reg <= psel_reg;
        end
        if (pv2_reg)
        begin
            rnd_reg <= ACC_W'(prod_rnd);
            case (psel2_reg)
                MS_TX_A: t_reg[2] <= ACC_W'(prod_rnd);
                MS_TX_B: t_reg[2] <= t_reg[2] + ACC_W'(prod_rnd);
                MS_TY_A: t_reg[5] <= ACC_W'(prod_rnd);
                MS_TY_B: t_reg[5] <= t_reg[5] - ACC_W'(prod_rnd);
                MS_SX:   t_reg[2] <= ACC_W'(prod_rnd);
                MS_SY:   t_reg[5] <= ACC_W'(prod_rnd);
                default: ;
            endcase
        end
        if (cmd.t_sat)
        begin
            for (int k = 0; k < 6; k++)
                ts_reg[k] <= sat(t_reg[k]);
            ovf_reg <= ovf_reg | clips(t_reg[0]) | clips(t_reg[1]) | clips(t_reg[2])
                     | clips(t_reg[3]) | clips(t_reg[4]) | clips(t_reg[5]);
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= (kcol == 2'd2) ? ACC_W'(ts_reg[r_base + 3'd2]) : '0;
        end
        if (cmd.acc_add && !cmd.n_write)
        begin
            acc_reg <= acc_sum;
        end
        if (cmd.n_write)
        begin
            n_reg[cmd.n_idx] <= sat(acc_sum);
            ovf_reg <= ovf_reg | clips(acc_sum);
        end
    end

    assign m00 = mat_reg[0];
    assign m01 = mat_reg[1];
    assign m02 = mat_reg[2];
    assign m10 = mat_reg[3];
    assign m11 = mat_reg[4];
    assign m12 = mat_reg[5];

endmodule

FILE: hw/rtl/affine_2d_transform_composer_top.sv
// top level of the 2d affine transform composer
// throughput: one request at a time; the 28-step cordic and the shared multiplier set the time
// a new request is taken the cycle after the previous result has been taken
// reset: asynchronous active low; the stored matrix returns to identity
module affine_2d_transform_composer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [31:0] param_x,
    input  logic signed [31:0] param_y,
    input  logic [15:0]        angle,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] m00,
    output logic signed [31:0] m01,
    output logic signed [31:0] m02,
    output logic signed [31:0] m10,
    output logic signed [31:0] m11,
    output logic signed [31:0] m12,
    output logic               overflow
);
    import atc_pkg::*;

    atc_cmd_t    cmd;
    atc_status_t status;

    atc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
    );

    atc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status), .action(action),
        .param_x(param_x), .param_y(param_y), .angle(angle),
        .center_x(center_x), .center_y(center_y),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .overflow(overflow)
    );

endmodule

FILE: hw/rtl/atc_checker.sv
// port-level checker for the affine transform composer, bound to the top level
module atc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] m00,
    input logic        overflow
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(overflow))
        else $error("result dropped or changed while stalled");

    a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while result pending");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result appeared too early");

    a_ready_low_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");
endmodule

bind affine_2d_transform_composer_top atc_checker u_atc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .m00(m00), .overflow(overflow)
);
